### sv/tmsd_pkg.sv
// ----------------------------------------------------------------------------
// tmsd_pkg
// Shared widths, default sizes and the sequencer state type of the trailing
// median spike detector.
// ----------------------------------------------------------------------------
package tmsd_pkg;

  // Default histogram size and ring depth.
  localparam int BINS_DEF       = 256;
  localparam int WINDOW_MAX_DEF = 1024;

  // Fixed field widths.
  localparam int SAMPLE_W = 8;
  localparam int WIN_W    = 11;
  localparam int CNT_W    = 11;
  localparam int TM_W     = 9;
  localparam int NOTICE_W = 16;

  // Running sum of bin counts: a count plus a partial sum below 2^WIN_W.
  localparam int RUN_W = WIN_W + 1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RD_OLD,
    ST_WR_OLD,
    ST_RD_NEW,
    ST_WR_NEW,
    ST_DONE
  } state_e;

endpackage

### sv/trailing_median_spike_detector.sv
// ----------------------------------------------------------------------------
// trailing_median_spike_detector
// Flags a sample that reaches twice the median of the trailing window.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one word, spend_i.
//   Each accepted word yields exactly one result word on the output channel
//   (out_valid_o / out_ready_i): notify, window_full, twice_median and the
//   saturating notice count.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the window
//   length. A write restarts the window and clears the histogram; the notice
//   count is kept. Write it only while the block is idle.
//   One item is handled at a time. Once the window is full, a scan of the
//   histogram memory, one bin read per cycle, stops at the bin k that holds
//   the median; read-modify-write of the retired and the new bin follows.
//   With a partial window the scan and the retired bin are skipped, and only
//   the new bin is updated before the result is written.
//   After reset, and after each configuration write, a clearing pass over
//   all BINS bins zeroes the histogram; no input word is taken during it.
//   The result sits in an output register. While the receiver stalls, the
//   next word is still accepted and processed, and it waits at the end of
//   its processing until the output register frees up.
// ----------------------------------------------------------------------------
module trailing_median_spike_detector #(
  parameter int BINS       = tmsd_pkg::BINS_DEF,
  parameter int WINDOW_MAX = tmsd_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tmsd_pkg::WIN_W-1:0]    cfg_window_days_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tmsd_pkg::SAMPLE_W-1:0] spend_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          notify_o,
  output logic                          window_full_o,
  output logic [tmsd_pkg::TM_W-1:0]     twice_median_o,
  output logic [tmsd_pkg::NOTICE_W-1:0] notice_count_o
);
  import tmsd_pkg::*;

  localparam int BW  = $clog2(BINS);
  localparam int SW  = $clog2(WINDOW_MAX);
  localparam int TMW = BW + 1;
  localparam logic [BW-1:0] LAST_BIN = BW'(BINS - 1);

  // Memories.
  logic [CNT_W-1:0]    hist_mem [BINS];
  logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];

  // Control registers.
  state_e              state_q, state_d;
  logic [WIN_W-1:0]    win_q, win_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [WIN_W-1:0]    seen_q, seen_d;
  logic [NOTICE_W-1:0] notices_q, notices_d;
  logic                out_valid_q, out_valid_d;
  logic [BW-1:0]       rd_addr_q, rd_addr_d;
  logic                issue_done_q, issue_done_d;
  logic                dv_q, dv_d;
  logic [BW-1:0]       clr_addr_q, clr_addr_d;
  logic                phase_q, phase_d;

  // Datapath registers.
  logic [BW-1:0]       s_q, s_d;
  logic                full_q, full_d;
  logic [TMW-1:0]      tm_q, tm_d;
  logic [RUN_W-1:0]    run_q, run_d;
  logic [BW-1:0]       i0_q, i0_d;
  logic [BW-1:0]       didx_q;
  logic [BW-1:0]       old_q, old_d;
  logic                notify_q, notify_d;
  logic                wfull_q, wfull_d;
  logic [TM_W-1:0]     tmo_q, tmo_d;

  // Memory read data and port controls.
  logic [CNT_W-1:0]    hist_rdata_q;
  logic [SAMPLE_W-1:0] ring_rdata_q;
  logic [BW-1:0]       hist_raddr;
  logic                hist_we;
  logic [BW-1:0]       hist_waddr;
  logic [CNT_W-1:0]    hist_wdata;
  logic                ring_we;

  // Handshakes and helper values.
  logic                cfg_fire, in_fire, out_fire, out_free;
  logic [WIN_W-1:0]    w_eff;
  logic [BW-1:0]       s_clamped;
  logic [RUN_W-1:0]    run_sum;
  logic                scan_hit;
  logic                note;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_free    = !out_valid_q || out_ready_i;

  // Effective window length: zero acts as one, long windows are capped.
  always_comb begin
    if (win_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (32'(win_q) > 32'(WINDOW_MAX)) begin
      w_eff = WIN_W'(WINDOW_MAX);
    end else begin
      w_eff = win_q;
    end
  end

  // Samples beyond the last bin fall into the last bin.
  always_comb begin
    if (13'(spend_i) >= 13'(BINS)) begin
      s_clamped = LAST_BIN;
    end else begin
      s_clamped = BW'(spend_i);
    end
  end

  // Scan step: one bin count per cycle, lower middle then upper middle.
  assign run_sum = run_q + RUN_W'(hist_rdata_q);
  always_comb begin
    scan_hit = 1'b0;
    tm_d     = tm_q;
    run_d    = run_q;
    phase_d  = phase_q;
    i0_d     = i0_q;
    if (state_q == ST_SCAN && dv_q) begin
      if (!phase_q) begin
        if ({run_sum, 1'b0} > (RUN_W + 1)'(w_eff)) begin
          tm_d     = {didx_q, 1'b0};
          scan_hit = 1'b1;
        end else if ({run_sum, 1'b0} == (RUN_W + 1)'(w_eff)) begin
          phase_d = 1'b1;
          i0_d    = didx_q;
          if (didx_q == LAST_BIN) begin
            tm_d     = {didx_q, 1'b0};
            scan_hit = 1'b1;
          end
        end else if (didx_q == LAST_BIN) begin
          tm_d     = '0;
          scan_hit = 1'b1;
        end
        run_d = run_sum;
      end else begin
        if (hist_rdata_q != '0) begin
          tm_d     = TMW'(i0_q) + TMW'(didx_q);
          scan_hit = 1'b1;
        end else if (didx_q == LAST_BIN) begin
          tm_d     = {i0_q, 1'b0};
          scan_hit = 1'b1;
        end
      end
    end
    if (in_fire) begin
      tm_d    = '0;
      run_d   = '0;
      phase_d = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_addr_q == LAST_BIN) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) state_d = (seen_q >= w_eff) ? ST_SCAN : ST_RD_NEW;
      end
      ST_SCAN:   if (scan_hit) state_d = ST_RD_OLD;
      ST_RD_OLD: state_d = ST_WR_OLD;
      ST_WR_OLD: state_d = ST_RD_NEW;
      ST_RD_NEW: state_d = ST_WR_NEW;
      ST_WR_NEW: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
    if (cfg_fire) state_d = ST_CLEAR;
  end

  // Memory ports and remaining register updates.
  assign note = full_q && (TMW'(s_q) >= tm_q);

  always_comb begin
    win_d        = win_q;
    slot_d       = slot_q;
    seen_d       = seen_q;
    notices_d    = notices_q;
    out_valid_d  = out_valid_q;
    rd_addr_d    = rd_addr_q;
    issue_done_d = issue_done_q;
    dv_d         = (state_q == ST_SCAN) && !issue_done_q;
    clr_addr_d   = clr_addr_q;
    s_d          = s_q;
    full_d       = full_q;
    old_d        = old_q;
    notify_d     = notify_q;
    wfull_d      = wfull_q;
    tmo_d        = tmo_q;
    hist_raddr   = rd_addr_q;
    hist_we      = 1'b0;
    hist_waddr   = s_q;
    hist_wdata   = '0;
    ring_we      = 1'b0;

    if (out_fire) out_valid_d = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_addr_q;
        hist_wdata = '0;
        clr_addr_d = clr_addr_q + BW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          s_d          = s_clamped;
          full_d       = (seen_q >= w_eff);
          rd_addr_d    = '0;
          issue_done_d = 1'b0;
          if (32'(slot_q) >= 32'(w_eff)) slot_d = '0;
        end
      end
      ST_SCAN: begin
        hist_raddr = rd_addr_q;
        if (rd_addr_q == LAST_BIN) begin
          issue_done_d = 1'b1;
        end else begin
          rd_addr_d = rd_addr_q + BW'(1);
        end
      end
      ST_RD_OLD: begin
        old_d      = BW'(ring_rdata_q);
        hist_raddr = BW'(ring_rdata_q);
      end
      ST_WR_OLD: begin
        hist_waddr = old_q;
        hist_we    = (hist_rdata_q != '0);
        hist_wdata = hist_rdata_q - CNT_W'(1);
      end
      ST_RD_NEW: begin
        hist_raddr = s_q;
      end
      ST_WR_NEW: begin
        hist_waddr = s_q;
        hist_we    = (hist_rdata_q != '1);
        hist_wdata = hist_rdata_q + CNT_W'(1);
        ring_we    = 1'b1;
        if (!full_q) seen_d = seen_q + WIN_W'(1);
        if (32'(slot_q) + 32'd1 >= 32'(w_eff)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + SW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          notify_d    = note;
          wfull_d     = full_q;
          tmo_d       = TM_W'(tm_q);
          if (note && notices_q != '1) begin
            notices_d = notices_q + NOTICE_W'(1);
          end
        end
      end
      default: ;
    endcase

    // A configuration write restarts the window.
    if (cfg_fire) begin
      win_d      = cfg_window_days_i;
      slot_d     = '0;
      seen_d     = '0;
      clr_addr_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      win_q        <= WIN_W'(1);
      slot_q       <= '0;
      seen_q       <= '0;
      notices_q    <= '0;
      out_valid_q  <= 1'b0;
      rd_addr_q    <= '0;
      issue_done_q <= 1'b0;
      dv_q         <= 1'b0;
      clr_addr_q   <= '0;
      phase_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      win_q        <= win_d;
      slot_q       <= slot_d;
      seen_q       <= seen_d;
      notices_q    <= notices_d;
      out_valid_q  <= out_valid_d;
      rd_addr_q    <= rd_addr_d;
      issue_done_q <= issue_done_d;
      dv_q         <= dv_d;
      clr_addr_q   <= clr_addr_d;
      phase_q      <= phase_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    full_q   <= full_d;
    tm_q     <= tm_d;
    run_q    <= run_d;
    i0_q     <= i0_d;
    didx_q   <= rd_addr_q;
    old_q    <= old_d;
    notify_q <= notify_d;
    wfull_q  <= wfull_d;
    tmo_q    <= tmo_d;
  end

  // Histogram memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata_q <= hist_mem[hist_raddr];
  end

  // Sample ring: read at the current slot, written with the new sample.
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[slot_q] <= SAMPLE_W'(s_q);
    ring_rdata_q <= ring_mem[slot_q];
  end

  assign out_valid_o    = out_valid_q;
  assign notify_o       = notify_q;
  assign window_full_o  = wfull_q;
  assign twice_median_o = tmo_q;
  assign notice_count_o = notices_q;

  // A notice is only raised against a full window.
  a_notify_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!notify_o || window_full_o))
    else $error("notify without a full window");

  // The median reads as zero until the window is full.
  a_tm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_full_o) |-> (twice_median_o == '0))
    else $error("nonzero median with a partial window");

  // The notice count only steps by one.
  a_notice_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (notices_q != $past(notices_q)) |-> (notices_q == $past(notices_q) + NOTICE_W'(1)))
    else $error("notice count jumped");

  // The fill count never exceeds the window.
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= w_eff)
    else $error("more samples held than the window");

  // The write slot stays inside the window while idle.
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (32'(slot_q) < 32'(w_eff)))
    else $error("write slot outside the window");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the trailing median spike detector
// Streams samples through the detector under several window lengths while a
// scoreboard keeps its own histogram and ring of the trailing window. Each
// result word is checked field by field against the prediction made when the
// matching sample word was accepted. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                          notify;
  logic                          window_full;
  logic [tmsd_pkg::TM_W-1:0]     twice_median;
  logic [tmsd_pkg::NOTICE_W-1:0] notice_count;
} spike_verdict_t;

// Tracks the trailing window and predicts one verdict per accepted sample.
class median_tracker;
  logic [tmsd_pkg::WIN_W-1:0]                   window_reg;
  logic [tmsd_pkg::CNT_W-1:0]                   bin_count [tmsd_pkg::BINS_DEF];
  logic [tmsd_pkg::SAMPLE_W-1:0]                ring [tmsd_pkg::WINDOW_MAX_DEF];
  logic [$clog2(tmsd_pkg::WINDOW_MAX_DEF)-1:0]  slot;
  logic [tmsd_pkg::WIN_W-1:0]                   held;
  logic [tmsd_pkg::NOTICE_W-1:0]                notices;
  spike_verdict_t                               pending_verdicts [$];
  int                                           faults;
  int                                           samples;
  int                                           compares;
  int                                           flagged;

  function new();
    notices  = '0;
    faults   = 0;
    samples  = 0;
    compares = 0;
    flagged  = 0;
    restart(1);
  endfunction

  // A window write clears the histogram and the fill level, not the count.
  function void restart(logic [tmsd_pkg::WIN_W-1:0] days);
    window_reg = days;
    foreach (bin_count[i]) bin_count[i] = '0;
    slot = '0;
    held = '0;
  endfunction

  function int unsigned span();
    int unsigned w;
    w = window_reg;
    if (w < 1) w = 1;
    if (w > tmsd_pkg::WINDOW_MAX_DEF) w = tmsd_pkg::WINDOW_MAX_DEF;
    return w;
  endfunction

  // Cumulative scan; for an even window the two middle values are added.
  function logic [tmsd_pkg::TM_W-1:0] median_x2(int unsigned w);
    int unsigned run;
    run = 0;
    for (int i = 0; i < tmsd_pkg::BINS_DEF; i++) begin
      run += bin_count[i];
      if (2 * run > w) return tmsd_pkg::TM_W'(2 * i);
      if (2 * run == w) begin
        for (int j = i + 1; j < tmsd_pkg::BINS_DEF; j++) begin
          if (bin_count[j] != 0) return tmsd_pkg::TM_W'(i + j);
        end
        return tmsd_pkg::TM_W'(2 * i);
      end
    end
    return '0;
  endfunction

  function void note_sample(logic [tmsd_pkg::SAMPLE_W-1:0] spend);
    int unsigned                   w;
    logic [tmsd_pkg::SAMPLE_W-1:0] oldest;
    spike_verdict_t                v;
    w = span();
    v = '0;
    samples++;
    if (slot >= w) slot = '0;
    if (held >= w) begin
      v.window_full  = 1'b1;
      v.twice_median = median_x2(w);
      compares++;
      if (spend >= v.twice_median) begin
        v.notify = 1'b1;
        flagged++;
        if (notices != '1) notices++;
      end
      oldest = ring[slot];
      if (bin_count[oldest] != 0) bin_count[oldest]--;
    end else begin
      held++;
    end
    ring[slot] = spend;
    if (bin_count[spend] != '1) bin_count[spend]++;
    slot++;
    if (slot >= w) slot = '0;
    v.notice_count = notices;
    pending_verdicts.push_back(v);
  endfunction

  function void check_result(spike_verdict_t got);
    spike_verdict_t want;
    if (pending_verdicts.size() == 0) begin
      $error("result word with no sample outstanding: notify %0d full %0d tm %0d count %0d",
             got.notify, got.window_full, got.twice_median, got.notice_count);
      faults++;
      return;
    end
    want = pending_verdicts.pop_front();
    if (got.notify !== want.notify) begin
      $error("notify: expected %0d, got %0d", want.notify, got.notify);
      faults++;
    end
    if (got.window_full !== want.window_full) begin
      $error("window_full: expected %0d, got %0d", want.window_full, got.window_full);
      faults++;
    end
    if (got.twice_median !== want.twice_median) begin
      $error("twice_median: expected %0d, got %0d", want.twice_median, got.twice_median);
      faults++;
    end
    if (got.notice_count !== want.notice_count) begin
      $error("notice_count: expected %0d, got %0d", want.notice_count, got.notice_count);
      faults++;
    end
  endfunction

  function int pending();
    return pending_verdicts.size();
  endfunction
endclass

module testbench;
  import tmsd_pkg::*;

  // A full-window item may scan every bin, and a window write starts a clearing
  // pass over every bin; the limit leaves ample room for stalls.
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 12;
  localparam int TAIL        = 300;

  // Short directed sequences: extremes, exact equality, restart mid-fill.
  localparam logic [SAMPLE_W-1:0] SEQ_SINGLE [10] = '{0, 0, 255, 255, 127, 254, 253, 1, 2, 3};
  localparam logic [SAMPLE_W-1:0] SEQ_PAIR   [8]  = '{10, 30, 20, 40, 100, 0, 0, 1};
  localparam logic [SAMPLE_W-1:0] SEQ_HUGE   [3]  = '{200, 7, 9};
  localparam logic [SAMPLE_W-1:0] SEQ_ZERO   [3]  = '{4, 8, 3};

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                cfg_valid_i       = 1'b0;
  logic                cfg_ready_o;
  logic [WIN_W-1:0]    cfg_window_days_i = '0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] spend_i           = '0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic                notify_o;
  logic                window_full_o;
  logic [TM_W-1:0]     twice_median_o;
  logic [NOTICE_W-1:0] notice_count_o;

  median_tracker tracker = new();
  bit            steady  = 1'b0;
  int            stuck   = 0;
  int            settings = 0;

  trailing_median_spike_detector dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_days_i (cfg_window_days_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .spend_i           (spend_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .notify_o          (notify_o),
    .window_full_o     (window_full_o),
    .twice_median_o    (twice_median_o),
    .notice_count_o    (notice_count_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result side: check each accepted word, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result({notify_o, window_full_o, twice_median_o, notice_count_o});
    end
    out_ready_i <= steady || ($urandom_range(99) >= 12);
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sends one sample word, optionally after the pipeline has drained.
  task automatic push_sample(input logic [SAMPLE_W-1:0] spend, input bit drain_first);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 12) gap++;
    end
    if (drain_first || gap > 0) begin
      in_valid_i <= 1'b0;
      if (drain_first) begin
        do @(posedge clk_i); while (tracker.pending() != 0);
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    spend_i    <= spend;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_sample(spend);
  endtask

  // Writes the window length once every result is back and the block is idle.
  task automatic write_window(input logic [WIN_W-1:0] days);
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_window_days_i <= days;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.restart(days);
    settings++;
  endtask

  // Mostly samples around a baseline, with spikes near twice the baseline
  // and some values drawn from the whole range.
  function automatic logic [SAMPLE_W-1:0] draw_spend(int base);
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 10) begin
      v = $urandom_range(255);
    end else if (roll < 22) begin
      v = 2 * base + $urandom_range(8) - 4;
    end else begin
      v = base + $urandom_range(16);
    end
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return SAMPLE_W'(v);
  endfunction

  task automatic run_random(input logic [WIN_W-1:0] days, input int count, input bit calm);
    int base;
    base = $urandom_range(100);
    write_window(days);
    steady = calm;
    for (int k = 0; k < count; k++) begin
      push_sample(draw_spend(base), k == count / 2);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset window of one, then an even window, an oversized
    // window that acts as the maximum, and a zero window that acts as one.
    foreach (SEQ_SINGLE[i]) push_sample(SEQ_SINGLE[i], 1'b0);
    in_valid_i <= 1'b0;
    write_window(2);
    foreach (SEQ_PAIR[i]) push_sample(SEQ_PAIR[i], 1'b0);
    in_valid_i <= 1'b0;
    write_window(2047);
    foreach (SEQ_HUGE[i]) push_sample(SEQ_HUGE[i], 1'b0);
    in_valid_i <= 1'b0;
    write_window(0);
    foreach (SEQ_ZERO[i]) push_sample(SEQ_ZERO[i], 1'b0);
    in_valid_i <= 1'b0;

    // Random part; the largest window fills cheaply, so it gets one phase.
    run_random(3, 120, 1'b0);
    run_random(2, 120, 1'b1);
    run_random(1024, 1060, 1'b0);
    run_random(5, 80, 1'b0);
    run_random(4, 80, 1'b0);
    run_random(WIN_W'($urandom_range(1, 40)), 60, 1'b0);
    run_random(WIN_W'($urandom_range(1, 40)), 60, 1'b0);
    run_random(1, 40, 1'b0);

    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (TAIL) @(posedge clk_i);

    $display("Sent %0d samples across %0d window writes, windows from 0 to 2047.",
             tracker.samples, settings);
    $display("Full-window comparisons: %0d, spikes flagged: %0d, mismatches: %0d.",
             tracker.compares, tracker.flagged, tracker.faults);
    if (tracker.faults == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
